// File: rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types, codes and the control store for the range-add / range-sum
// Fenwick unit.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam logic [10:0] SIZE_RESET = 11'd1024;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SUM   = 2'd2;
    localparam logic [1:0] OP_RSV   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [10:0]        left_index;
        logic [10:0]        right_index;
        logic signed [31:0] amount;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] range_sum;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic [63:0] diff;
        logic [63:0] wdiff;
    } t_tree_word;

    typedef logic [4:0] t_upc;

    typedef enum logic [3:0] {
        POS_HOLD, POS_LEFT, POS_END, POS_RIGHT, POS_LEFTM1,
        POS_UP, POS_DOWN, POS_ZERO, POS_INC
    } t_pos_op;

    typedef enum logic [1:0] {VAL_HOLD, VAL_AMT, VAL_NAMT} t_val_op;
    typedef enum logic [1:0] {WGT_HOLD, WGT_PROD, WGT_NPROD} t_wgt_op;
    typedef enum logic [1:0] {MUL_NONE, MUL_W, MUL_LO, MUL_HI} t_mul_op;
    typedef enum logic [1:0] {SUM_HOLD, SUM_CLR, SUM_ADD} t_sum_op;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_ADD_PROD, ACC_SUB_PROD, ACC_ADD_HI, ACC_SUB_HI,
        ACC_ADD_S2, ACC_SUB_S2
    } t_acc_op;

    typedef enum logic [2:0] {
        COND_NONE, COND_ALWAYS, COND_OUT, COND_ZERO, COND_MORE
    } t_cond;

    typedef struct packed {
        t_pos_op pos_op;
        t_val_op val_op;
        t_wgt_op wgt_op;
        t_mul_op mul_op;
        t_sum_op sum_op;
        t_acc_op acc_op;
        logic    mem_rd;
        logic    mem_wr;
        logic    wr_zero;
        logic    fin;
        t_cond   cond;
        t_upc    target;
    } t_uword;

    typedef struct packed {
        logic pos_zero;
        logic pos_out;
        logic pos_more;
    } t_dp_flags;

    localparam t_upc U_ADD       = 5'd0;
    localparam t_upc U_ADD_WALK1 = 5'd3;
    localparam t_upc U_ADD_END   = 5'd5;
    localparam t_upc U_ADD_WALK2 = 5'd8;
    localparam t_upc U_FIN       = 5'd10;
    localparam t_upc U_SUM       = 5'd11;
    localparam t_upc U_SUM_WALK1 = 5'd12;
    localparam t_upc U_SUM_MUL1  = 5'd14;
    localparam t_upc U_SUM_WALK2 = 5'd19;
    localparam t_upc U_SUM_MUL2  = 5'd21;
    localparam t_upc U_CLR       = 5'd25;
    localparam t_upc U_CLR_LOOP  = 5'd26;

    function automatic t_upc rfa_entry(input logic [1:0] op, input logic bad);
        t_upc pc;
        priority if (op == OP_CLEAR) begin
            pc = U_CLR;
        end else if (op == OP_RSV || bad) begin
            pc = U_FIN;
        end else if (op == OP_ADD) begin
            pc = U_ADD;
        end else begin
            pc = U_SUM;
        end
        return pc;
    endfunction

    function automatic t_uword rfa_ucode(input t_upc pc);
        t_uword uw;
        uw = '0;
        unique case (pc)
            5'd0: begin
                uw.pos_op = POS_LEFT;
                uw.val_op = VAL_AMT;
            end
            5'd1: begin
                uw.mul_op = MUL_W;
            end
            5'd2: begin
                uw.wgt_op = WGT_PROD;
            end
            5'd3: begin
                uw.mem_rd = 1'b1;
                uw.cond   = COND_OUT;
                uw.target = U_ADD_END;
            end
            5'd4: begin
                uw.mem_wr = 1'b1;
                uw.pos_op = POS_UP;
                uw.cond   = COND_ALWAYS;
                uw.target = U_ADD_WALK1;
            end
            5'd5: begin
                uw.pos_op = POS_END;
                uw.val_op = VAL_NAMT;
            end
            5'd6: begin
                uw.mul_op = MUL_W;
                uw.cond   = COND_OUT;
                uw.target = U_FIN;
            end
            5'd7: begin
                uw.wgt_op = WGT_NPROD;
            end
            5'd8: begin
                uw.mem_rd = 1'b1;
                uw.cond   = COND_OUT;
                uw.target = U_FIN;
            end
            5'd9: begin
                uw.mem_wr = 1'b1;
                uw.pos_op = POS_UP;
                uw.cond   = COND_ALWAYS;
                uw.target = U_ADD_WALK2;
            end
            5'd10: begin
                uw.fin = 1'b1;
            end
            5'd11: begin
                uw.pos_op = POS_RIGHT;
                uw.sum_op = SUM_CLR;
            end
            5'd12: begin
                uw.mem_rd = 1'b1;
                uw.cond   = COND_ZERO;
                uw.target = U_SUM_MUL1;
            end
            5'd13: begin
                uw.sum_op = SUM_ADD;
                uw.pos_op = POS_DOWN;
                uw.cond   = COND_ALWAYS;
                uw.target = U_SUM_WALK1;
            end
            5'd14: begin
                uw.mul_op = MUL_LO;
            end
            5'd15: begin
                uw.acc_op = ACC_ADD_PROD;
                uw.mul_op = MUL_HI;
            end
            5'd16: begin
                uw.acc_op = ACC_ADD_HI;
            end
            5'd17: begin
                uw.acc_op = ACC_SUB_S2;
            end
            5'd18: begin
                uw.pos_op = POS_LEFTM1;
                uw.sum_op = SUM_CLR;
            end
            5'd19: begin
                uw.mem_rd = 1'b1;
                uw.cond   = COND_ZERO;
                uw.target = U_SUM_MUL2;
            end
            5'd20: begin
                uw.sum_op = SUM_ADD;
                uw.pos_op = POS_DOWN;
                uw.cond   = COND_ALWAYS;
                uw.target = U_SUM_WALK2;
            end
            5'd21: begin
                uw.mul_op = MUL_LO;
            end
            5'd22: begin
                uw.acc_op = ACC_SUB_PROD;
                uw.mul_op = MUL_HI;
            end
            5'd23: begin
                uw.acc_op = ACC_SUB_HI;
            end
            5'd24: begin
                uw.acc_op = ACC_ADD_S2;
                uw.cond   = COND_ALWAYS;
                uw.target = U_FIN;
            end
            5'd25: begin
                uw.pos_op = POS_ZERO;
            end
            5'd26: begin
                uw.mem_wr  = 1'b1;
                uw.wr_zero = 1'b1;
                uw.pos_op  = POS_INC;
                uw.cond    = COND_MORE;
                uw.target  = U_CLR_LOOP;
            end
            5'd27: begin
                uw.cond   = COND_ALWAYS;
                uw.target = U_FIN;
            end
            default: begin
                uw.cond   = COND_ALWAYS;
                uw.target = U_FIN;
            end
        endcase
        return uw;
    endfunction

endpackage

// File: rtl/rfa_tree_ram.sv
// ----------------------------------------------------------------------------
// rfa_tree_ram
// Single-port store holding one entry of both trees per position, with a
// registered read port.
// ----------------------------------------------------------------------------
module rfa_tree_ram #(
    parameter int CAPACITY = rfa_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_addr,
    input  logic               i_rd,
    input  logic               i_wr,
    input  rfa_pkg::t_tree_word i_wdata,
    output rfa_pkg::t_tree_word o_rdata
);
    import rfa_pkg::*;

    localparam int DEPTH = CAPACITY + 1;

    t_tree_word r_mem [DEPTH];
    t_tree_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rfa_datapath.sv
// ----------------------------------------------------------------------------
// rfa_datapath
// Position walker, shared multiplier, prefix sums and result accumulator,
// driven one control word per cycle.
// ----------------------------------------------------------------------------
module rfa_datapath #(
    parameter int CAPACITY = rfa_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_start,
    input  rfa_pkg::t_in_item   i_item,
    input  rfa_pkg::t_uword     i_uw,
    output rfa_pkg::t_dp_flags  o_flags,
    output logic [AW-1:0]       o_ram_addr,
    output logic                o_ram_rd,
    output logic                o_ram_wr,
    output rfa_pkg::t_tree_word o_ram_wdata,
    input  rfa_pkg::t_tree_word i_ram_rdata,
    output logic [63:0]         o_sum
);
    import rfa_pkg::*;

    localparam int PW  = AW + 1;
    localparam int MBW = PW + 1;
    localparam int PRW = 33 + MBW;

    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        r_x;
    logic [PW-1:0]        r_left;
    logic [PW-1:0]        r_right;
    logic signed [31:0]   r_amt;
    logic [63:0]          r_val;
    logic [63:0]          r_wgt;
    logic [63:0]          r_prod;
    logic [63:0]          r_s1;
    logic [63:0]          r_s2;
    logic [63:0]          r_acc;

    logic [PW-1:0]        lowbit;
    logic [PW-1:0]        x_inc;
    logic [PW-1:0]        pos_new;
    logic [63:0]          amt64;
    logic signed [32:0]   mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PRW-1:0] mul_p;
    logic                 pos_zero;

    assign lowbit   = r_pos & (~r_pos + PW'(1));
    assign x_inc    = r_x + PW'(1);
    assign amt64    = 64'(r_amt);
    assign pos_zero = (r_pos == '0);

    assign o_flags.pos_zero = pos_zero;
    assign o_flags.pos_out  = pos_zero || (r_pos > PW'(CAPACITY));
    assign o_flags.pos_more = (r_pos != PW'(CAPACITY));

    always_comb begin
        unique case (i_uw.mul_op)
            MUL_W: begin
                mul_a = {r_amt[31], r_amt};
                mul_b = {1'b0, r_pos};
            end
            MUL_LO: begin
                mul_a = {1'b0, r_s1[31:0]};
                mul_b = {1'b0, x_inc};
            end
            MUL_HI: begin
                mul_a = {1'b0, r_s1[63:32]};
                mul_b = {1'b0, x_inc};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (i_uw.pos_op)
            POS_LEFT:   pos_new = r_left;
            POS_END:    pos_new = r_right + PW'(1);
            POS_RIGHT:  pos_new = r_right;
            POS_LEFTM1: pos_new = r_left - PW'(1);
            POS_UP:     pos_new = r_pos + lowbit;
            POS_DOWN:   pos_new = r_pos - lowbit;
            POS_ZERO:   pos_new = '0;
            POS_INC:    pos_new = r_pos + PW'(1);
            default:    pos_new = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos <= pos_new;
        if (i_uw.pos_op == POS_RIGHT || i_uw.pos_op == POS_LEFTM1) begin
            r_x <= pos_new;
        end

        if (i_start) begin
            r_left  <= PW'(i_item.left_index);
            r_right <= PW'(i_item.right_index);
            r_amt   <= i_item.amount;
        end

        unique case (i_uw.val_op)
            VAL_AMT:  r_val <= amt64;
            VAL_NAMT: r_val <= 64'd0 - amt64;
            default:  r_val <= r_val;
        endcase

        unique case (i_uw.wgt_op)
            WGT_PROD:  r_wgt <= r_prod;
            WGT_NPROD: r_wgt <= 64'd0 - r_prod;
            default:   r_wgt <= r_wgt;
        endcase

        if (i_uw.mul_op != MUL_NONE) begin
            r_prod <= 64'(mul_p);
        end

        unique case (i_uw.sum_op)
            SUM_CLR: begin
                r_s1 <= '0;
                r_s2 <= '0;
            end
            SUM_ADD: begin
                r_s1 <= r_s1 + i_ram_rdata.diff;
                r_s2 <= r_s2 + i_ram_rdata.wdiff;
            end
            default: begin
                r_s1 <= r_s1;
                r_s2 <= r_s2;
            end
        endcase

        if (i_start) begin
            r_acc <= '0;
        end else begin
            unique case (i_uw.acc_op)
                ACC_ADD_PROD: r_acc <= r_acc + r_prod;
                ACC_SUB_PROD: r_acc <= r_acc - r_prod;
                ACC_ADD_HI:   r_acc <= r_acc + {r_prod[31:0], 32'd0};
                ACC_SUB_HI:   r_acc <= r_acc - {r_prod[31:0], 32'd0};
                ACC_ADD_S2:   r_acc <= r_acc + r_s2;
                ACC_SUB_S2:   r_acc <= r_acc - r_s2;
                default:      r_acc <= r_acc;
            endcase
        end
    end

    assign o_ram_addr = r_pos[AW-1:0];
    assign o_ram_rd   = i_uw.mem_rd && !o_flags.pos_out;
    assign o_ram_wr   = i_uw.mem_wr;

    always_comb begin
        if (i_uw.wr_zero) begin
            o_ram_wdata = '0;
        end else begin
            o_ram_wdata.diff  = i_ram_rdata.diff + r_val;
            o_ram_wdata.wdiff = i_ram_rdata.wdiff + r_wgt;
        end
    end

    assign o_sum = r_acc;

endmodule

// File: rtl/rfa_sequencer.sv
// ----------------------------------------------------------------------------
// rfa_sequencer
// Step counter over the control store, with conditional jumps and dispatch
// to the program entry of each transfer.
// ----------------------------------------------------------------------------
module rfa_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rfa_pkg::t_upc      i_entry,
    input  rfa_pkg::t_dp_flags i_flags,
    input  logic               i_out_free,
    output logic               o_busy,
    output logic               o_done,
    output rfa_pkg::t_uword    o_uw
);
    import rfa_pkg::*;

    t_upc   r_pc;
    logic   r_busy;
    t_uword uw_rom;
    logic   taken;

    assign uw_rom = rfa_ucode(r_pc);
    assign o_uw   = r_busy ? uw_rom : '0;
    assign o_busy = r_busy;
    assign o_done = r_busy && uw_rom.fin && i_out_free;

    always_comb begin
        unique case (uw_rom.cond)
            COND_ALWAYS: taken = 1'b1;
            COND_OUT:    taken = i_flags.pos_out;
            COND_ZERO:   taken = i_flags.pos_zero;
            COND_MORE:   taken = i_flags.pos_more;
            default:     taken = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_pc   <= U_CLR;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= i_entry;
        end else if (r_busy) begin
            if (uw_rom.fin) begin
                if (i_out_free) begin
                    r_busy <= 1'b0;
                end
            end else if (taken) begin
                r_pc <= uw_rom.target;
            end else begin
                r_pc <= r_pc + 5'd1;
            end
        end
    end

endmodule

// File: rtl/range_add_range_sum_fenwick_unit.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_fenwick_unit
// Range add walks the trees in read-modify-write steps on the single store port;
// range sum walks them with a read and an accumulate per step; a bad range or
// reserved code goes straight to the result. Clear and reset sweep the store one
// entry per cycle, with the input held.
// Throughput: one item at a time; the next is taken while a result waits.
// ----------------------------------------------------------------------------
module range_add_range_sum_fenwick_unit #(
    parameter int CAPACITY = rfa_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rfa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rfa_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [10:0]        i_cfg_data
);
    import rfa_pkg::*;

    localparam int AW = $clog2(CAPACITY + 1);

    logic [10:0] r_size;
    logic        r_reply;
    logic        r_status;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        start;
    logic        busy;
    logic        done;
    logic        out_free;
    logic        bad;
    logic        status;
    t_upc        entry;
    t_uword      uw;
    t_dp_flags   flags;
    logic [AW-1:0] ram_addr;
    logic        ram_rd;
    logic        ram_wr;
    t_tree_word  ram_wdata;
    t_tree_word  ram_rdata;
    logic [63:0] sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !busy;
    assign start       = i_in_valid && !busy;
    assign out_free    = !r_out_valid || i_out_ready;

    assign bad = (i_in_item.left_index == 11'd0)
              || (i_in_item.left_index > i_in_item.right_index)
              || (i_in_item.right_index > r_size)
              || (32'(i_in_item.right_index) > 32'(CAPACITY));
    assign status = (i_in_item.opcode == OP_RSV)
                 || ((i_in_item.opcode != OP_CLEAR) && bad);
    assign entry  = rfa_entry(i_in_item.opcode, bad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (start) begin
                r_reply <= 1'b1;
            end
            if (done && r_reply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status <= status;
        end
        if (done && r_reply && out_free) begin
            r_out.range_sum <= sum;
            r_out.status    <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    rfa_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_entry    (entry),
        .i_flags    (flags),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_done     (done),
        .o_uw       (uw)
    );

    rfa_datapath #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_start     (start),
        .i_item      (i_in_item),
        .i_uw        (uw),
        .o_flags     (flags),
        .o_ram_addr  (ram_addr),
        .o_ram_rd    (ram_rd),
        .o_ram_wr    (ram_wr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_sum       (sum)
    );

    rfa_tree_ram #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_rd    (ram_rd),
        .i_wr    (ram_wr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule
